// File: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, codes and request/response types of the polygon guard.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_W      = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int PAD_W        = 24;
    localparam int CFG_IDX_W    = 2;

    // shared multiplier: differences of two coordinates plus a sign bit
    localparam int MUL_W  = COORD_W + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LEN2_W = 2 * COORD_W + 3;
    localparam int SUM_W  = COORD_W + ADDR_W;

    // long divider
    localparam int REM_W     = LEN2_W + 2;
    localparam int DEN_W     = LEN2_W + 1;
    localparam int NUM_W     = 80;
    localparam int QUO_W     = 40;
    localparam int DIV_CNT_W = 7;
    localparam int DIV_ITER_ALPHA = 32;
    localparam int DIV_ITER_CEN   = 40;
    localparam int DIV_ITER_DIR   = NUM_W;

    // square root
    localparam int SQ_RAD_W  = 100;
    localparam int ROOT_W    = SQ_RAD_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int SQ_CNT_W  = $clog2(ROOT_W + 1);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING      = 2'd1;

    typedef struct packed {
        logic                 start;
        logic [REM_W-1:0]     rem_init;
        logic [NUM_W-1:0]     num;
        logic [DEN_W-1:0]     den;
        logic [DIV_CNT_W-1:0] iter;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                start;
        logic [SQ_RAD_W-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: rtl/pip_vmem.sv
// ----------------------------------------------------------------------------
// pip_vmem
// Vertex store: x and y arrays, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_vmem import pip_pkg::*; (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [COORD_W-1:0] wr_x,
    input  logic signed [COORD_W-1:0] wr_y,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [COORD_W-1:0] rd_x,
    output logic signed [COORD_W-1:0] rd_y
);

    logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
    logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
    end

endmodule

// File: rtl/pip_div.sv
// ----------------------------------------------------------------------------
// pip_div
// Restoring long divider, one quotient bit per cycle, preloadable remainder.
// ----------------------------------------------------------------------------
module pip_div import pip_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [QUO_W-1:0]     quot_reg;

    logic [REM_W-1:0] rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign ge     = rem_sh >= REM_W'(den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iter;
                rem_reg  <= req.rem_init;
                num_reg  <= req.num;
                den_reg  <= req.den;
                quot_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_sh - REM_W'(den_reg) : rem_sh;
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                quot_reg <= {quot_reg[QUO_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: rtl/pip_isqrt.sv
// ----------------------------------------------------------------------------
// pip_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pip_isqrt import pip_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic                busy_reg;
    logic                done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SQ_RAD_W-1:0] rad_reg;
    logic [SQ_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;

    assign rem_sh = {rem_reg[SQ_REM_W-3:0], rad_reg[SQ_RAD_W-1 -: 2]};
    assign trial  = SQ_REM_W'({root_reg, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(ROOT_W);
                rad_reg  <= req.rad;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rem_reg  <= ge ? rem_sh - trial : rem_sh;
                rad_reg  <= {rad_reg[SQ_RAD_W-3:0], 2'b00};
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// File: rtl/project_point_inside_polygon_unit.sv
// ----------------------------------------------------------------------------
// project_point_inside_polygon_unit
// Even-odd polygon test with projection of outside points onto the boundary.
// ----------------------------------------------------------------------------
// A vertex load is written when it is accepted; a query is taken one at a time,
// as s_tready is high only in the idle state. With n vertices in use and n of at
// least three, the crossing pass walks every edge; a point found outside then
// takes a projection pass over every edge, as a short edge, a clamped edge or an
// interior projection with the alpha division, followed by the centroid, the root
// and the two direction divisions. Queries with fewer than three vertices go to
// the output unchanged. The shared 34x34 multiplier, the bit-serial divider and
// the vertex memory read port are used in turn by these steps. Vertex slots hold
// no defined value until they are loaded.
module project_point_inside_polygon_unit import pip_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [71:0]           s_tdata,  // vertex_index, coord_x, coord_y, zero fill
    input  logic                  s_tuser,  // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,  // result_x, result_y
    output logic                  m_tuser,  // was_projected
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PAD_W-1:0]      cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_C_PREV, ST_C_LOAD, ST_C_TEST, ST_C_MB, ST_C_CMP, ST_C_ADV,
        ST_P_V0, ST_P_LOADE, ST_P_D, ST_P_L1, ST_P_L2, ST_P_L3, ST_P_LCHK,
        ST_P_T2, ST_P_T3, ST_P_TCHK, ST_P_DIVA, ST_P_SA1, ST_P_SA2, ST_P_SA3,
        ST_P_DIST, ST_P_D2, ST_P_D3, ST_P_ADV, ST_P_CEN, ST_P_CX, ST_P_CY,
        ST_P_U0, ST_P_U1, ST_P_U2, ST_P_SQ, ST_P_S1, ST_P_S2, ST_P_SX,
        ST_P_S3, ST_P_SY, ST_FIN, ST_OUT
    } state_t;

    localparam logic [LEN2_W-1:0] LEN2_MIN = LEN2_W'(65536);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COORD_W - 1);

    state_t state_reg;

    logic [CNT_W-1:0] vcount_reg;
    logic [PAD_W-1:0] pad_reg;

    logic signed [COORD_W-1:0] qx_reg, qy_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, cvx_reg, cvy_reg;
    logic signed [COORD_W-1:0] v0x_reg, v0y_reg, sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg, bx_reg, by_reg;
    logic signed [COORD_W:0]   dx_reg, dy_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      inside_reg;
    logic signed [PROD_W-1:0]  t1_reg, mul_p_reg;
    logic [LEN2_W-1:0]         len2_reg, best_reg;
    logic signed [PROD_W:0]    dot_reg;
    logic [DIV_ITER_ALPHA-1:0] alpha_reg;
    logic signed [SUM_W-1:0]   sumx_reg, sumy_reg;
    logic signed [MUL_W-1:0]   ux_reg, uy_reg, stepx_reg, stepy_reg;
    logic [ROOT_W-1:0]         len_reg;
    logic signed [COORD_W-1:0] resx_reg, resy_reg;
    logic                      resp_reg;
    logic                      m_valid_reg;
    logic [63:0]               m_data_reg;
    logic                      m_user_reg;

    logic [CNT_W-1:0]          n_eff, last;
    logic                      s_accept;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [COORD_W-1:0] in_x, in_y;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0]  mul_next;
    logic signed [PROD_W:0]    psum;
    logic signed [PROD_W-1:0]  rnd_a, rnd_b;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    sqrt_req_t                 sqrt_req;
    sqrt_rsp_t                 sqrt_rsp;

    function automatic logic signed [COORD_W:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        return (COORD_W+1)'(a) - (COORD_W+1)'(b);
    endfunction

    function automatic logic signed [MUL_W-1:0] mabs(input logic signed [MUL_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    // numerator 2|sum| + n, left aligned for the centroid division
    function automatic logic [NUM_W-1:0] cen_num(input logic signed [SUM_W-1:0] s,
                                                 input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] m;
        logic [DIV_ITER_CEN-1:0] v;
        m = (s < 0) ? SUM_W'(-s) : SUM_W'(s);
        v = DIV_ITER_CEN'({m, 1'b0}) + DIV_ITER_CEN'(n);
        return {v, {(NUM_W-DIV_ITER_CEN){1'b0}}};
    endfunction

    function automatic logic signed [MUL_W-1:0] sgn_q(input logic neg,
                                                      input logic [QUO_W-1:0] q);
        logic signed [MUL_W-1:0] m;
        m = MUL_W'(q[COORD_W:0]);
        return neg ? -m : m;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [COORD_W-1:0] b,
                                                      input logic signed [MUL_W-1:0] st);
        logic signed [MUL_W:0] v;
        v = (MUL_W+1)'(b) + (MUL_W+1)'(st);
        if ((&v[MUL_W:COORD_W-1]) || !(|v[MUL_W:COORD_W-1])) begin
            return v[COORD_W-1:0];
        end
        return v[MUL_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    assign n_eff    = (vcount_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_reg;
    assign last     = n_eff - 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign in_x     = s_tdata[ADDR_W +: COORD_W];
    assign in_y     = s_tdata[ADDR_W+COORD_W +: COORD_W];
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    pip_vmem u_vmem (
        .aclk    (aclk),
        .wr_en   (s_accept && (s_tuser == CMD_LOAD)),
        .wr_addr (s_tdata[ADDR_W-1:0]),
        .wr_x    (in_x),
        .wr_y    (in_y),
        .rd_addr (rd_addr),
        .rd_x    (rd_x),
        .rd_y    (rd_y)
    );

    pip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    pip_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    always_comb begin
        unique case (state_reg)
            ST_IDLE:  rd_addr = last[ADDR_W-1:0];
            ST_C_ADV: rd_addr = (idx_reg == last) ? '0 : ADDR_W'(idx_reg + 1'b1);
            ST_P_V0:  rd_addr = ADDR_W'(1);
            ST_P_ADV: rd_addr = ADDR_W'(idx_reg + CNT_W'(2));
            default:  rd_addr = '0;
        endcase
    end

    // operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_C_TEST: begin
                op_a = MUL_W'(sdiff(qx_reg, cvx_reg));
                op_b = MUL_W'(sdiff(py_reg, cvy_reg));
            end
            ST_C_MB: begin
                op_a = MUL_W'(sdiff(px_reg, cvx_reg));
                op_b = MUL_W'(sdiff(qy_reg, cvy_reg));
            end
            ST_P_L1: begin
                op_a = MUL_W'(dx_reg);
                op_b = MUL_W'(dx_reg);
            end
            ST_P_L2: begin
                op_a = MUL_W'(dy_reg);
                op_b = MUL_W'(dy_reg);
            end
            ST_P_LCHK: begin
                op_a = MUL_W'(sdiff(qx_reg, sx_reg));
                op_b = MUL_W'(dx_reg);
            end
            ST_P_T2: begin
                op_a = MUL_W'(sdiff(qy_reg, sy_reg));
                op_b = MUL_W'(dy_reg);
            end
            ST_P_SA1: begin
                op_a = mabs(MUL_W'(dx_reg));
                op_b = MUL_W'(alpha_reg);
            end
            ST_P_SA2: begin
                op_a = mabs(MUL_W'(dy_reg));
                op_b = MUL_W'(alpha_reg);
            end
            ST_P_DIST: begin
                op_a = MUL_W'(sdiff(qx_reg, cx_reg));
                op_b = MUL_W'(sdiff(qx_reg, cx_reg));
            end
            ST_P_D2: begin
                op_a = MUL_W'(sdiff(qy_reg, cy_reg));
                op_b = MUL_W'(sdiff(qy_reg, cy_reg));
            end
            ST_P_U0: begin
                op_a = ux_reg;
                op_b = ux_reg;
            end
            ST_P_U1: begin
                op_a = uy_reg;
                op_b = uy_reg;
            end
            ST_P_S1: begin
                op_a = mabs(ux_reg);
                op_b = MUL_W'(pad_reg);
            end
            ST_P_SX: begin
                op_a = mabs(uy_reg);
                op_b = MUL_W'(pad_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_next = op_a * op_b;
    assign psum     = (PROD_W+1)'(t1_reg) + (PROD_W+1)'(mul_p_reg);
    assign rnd_a    = t1_reg + RND_HALF;
    assign rnd_b    = mul_p_reg + RND_HALF;

    always_comb begin
        div_req = '0;
        unique case (state_reg)
            ST_P_TCHK: begin
                div_req.start    = (dot_reg > 0) && (dot_reg < $signed({2'b00, len2_reg}));
                div_req.rem_init = REM_W'(dot_reg[LEN2_W-1:0]);
                div_req.den      = DEN_W'(len2_reg);
                div_req.iter     = DIV_CNT_W'(DIV_ITER_ALPHA);
            end
            ST_P_CEN: begin
                div_req.start = 1'b1;
                div_req.num   = cen_num(sumx_reg, n_eff);
                div_req.den   = DEN_W'({n_eff, 1'b0});
                div_req.iter  = DIV_CNT_W'(DIV_ITER_CEN);
            end
            ST_P_CX: begin
                div_req.start = div_rsp.done;
                div_req.num   = cen_num(sumy_reg, n_eff);
                div_req.den   = DEN_W'({n_eff, 1'b0});
                div_req.iter  = DIV_CNT_W'(DIV_ITER_CEN);
            end
            ST_P_S2, ST_P_S3: begin
                div_req.start = 1'b1;
                div_req.num   = {mul_p_reg[NUM_W-18:0], 17'b0} + NUM_W'(len_reg);
                div_req.den   = DEN_W'({len_reg, 1'b0});
                div_req.iter  = DIV_CNT_W'(DIV_ITER_DIR);
            end
            default: div_req = '0;
        endcase
    end

    assign sqrt_req.start = (state_reg == ST_P_U2);
    assign sqrt_req.rad   = SQ_RAD_W'({psum[LEN2_W-1:0], {COORD_W{1'b0}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vcount_reg  <= '0;
            pad_reg     <= '0;
        end else begin
            mul_p_reg <= mul_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT: vcount_reg <= cfg_data[CNT_W-1:0];
                    REG_PADDING:      pad_reg    <= cfg_data;
                    default:          ;
                endcase
            end
            // drop the item once taken, unless a new one replaces it below
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && (s_tuser == CMD_QUERY)) begin
                        qx_reg     <= in_x;
                        qy_reg     <= in_y;
                        resx_reg   <= in_x;
                        resy_reg   <= in_y;
                        resp_reg   <= 1'b0;
                        inside_reg <= 1'b0;
                        state_reg  <= (n_eff < CNT_W'(3)) ? ST_OUT : ST_C_PREV;
                    end
                end
                ST_C_PREV: begin
                    px_reg    <= rd_x;
                    py_reg    <= rd_y;
                    idx_reg   <= '0;
                    state_reg <= ST_C_LOAD;
                end
                ST_C_LOAD: begin
                    cvx_reg   <= rd_x;
                    cvy_reg   <= rd_y;
                    state_reg <= ST_C_TEST;
                end
                ST_C_TEST: begin
                    state_reg <= ((cvy_reg > qy_reg) != (py_reg > qy_reg)) ? ST_C_MB : ST_C_ADV;
                end
                ST_C_MB: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_C_CMP;
                end
                ST_C_CMP: begin
                    if ((sdiff(py_reg, cvy_reg) > 0) ? (t1_reg < mul_p_reg)
                                                     : (t1_reg > mul_p_reg)) begin
                        inside_reg <= !inside_reg;
                    end
                    state_reg <= ST_C_ADV;
                end
                ST_C_ADV: begin
                    px_reg  <= cvx_reg;
                    py_reg  <= cvy_reg;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg != last) begin
                        state_reg <= ST_C_LOAD;
                    end else if (inside_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_P_V0;
                    end
                end
                ST_P_V0: begin
                    v0x_reg   <= rd_x;
                    v0y_reg   <= rd_y;
                    sx_reg    <= rd_x;
                    sy_reg    <= rd_y;
                    idx_reg   <= '0;
                    sumx_reg  <= '0;
                    sumy_reg  <= '0;
                    state_reg <= ST_P_LOADE;
                end
                ST_P_LOADE: begin
                    ex_reg    <= (idx_reg == last) ? v0x_reg : rd_x;
                    ey_reg    <= (idx_reg == last) ? v0y_reg : rd_y;
                    sumx_reg  <= sumx_reg + SUM_W'(sx_reg);
                    sumy_reg  <= sumy_reg + SUM_W'(sy_reg);
                    state_reg <= ST_P_D;
                end
                ST_P_D: begin
                    dx_reg    <= sdiff(ex_reg, sx_reg);
                    dy_reg    <= sdiff(ey_reg, sy_reg);
                    state_reg <= ST_P_L1;
                end
                ST_P_L1: state_reg <= ST_P_L2;
                ST_P_L2: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_P_L3;
                end
                ST_P_L3: begin
                    len2_reg  <= psum[LEN2_W-1:0];
                    state_reg <= ST_P_LCHK;
                end
                ST_P_LCHK: begin
                    // short edge: take the start vertex
                    if (len2_reg <= LEN2_MIN) begin
                        cx_reg    <= sx_reg;
                        cy_reg    <= sy_reg;
                        state_reg <= ST_P_DIST;
                    end else begin
                        state_reg <= ST_P_T2;
                    end
                end
                ST_P_T2: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_P_T3;
                end
                ST_P_T3: begin
                    dot_reg   <= psum;
                    state_reg <= ST_P_TCHK;
                end
                ST_P_TCHK: begin
                    if (dot_reg <= 0) begin
                        cx_reg    <= sx_reg;
                        cy_reg    <= sy_reg;
                        state_reg <= ST_P_DIST;
                    end else if (dot_reg >= $signed({2'b00, len2_reg})) begin
                        cx_reg    <= ex_reg;
                        cy_reg    <= ey_reg;
                        state_reg <= ST_P_DIST;
                    end else begin
                        state_reg <= ST_P_DIVA;
                    end
                end
                ST_P_DIVA: begin
                    if (div_rsp.done) begin
                        alpha_reg <= div_rsp.quot[DIV_ITER_ALPHA-1:0];
                        state_reg <= ST_P_SA1;
                    end
                end
                ST_P_SA1: state_reg <= ST_P_SA2;
                ST_P_SA2: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_P_SA3;
                end
                ST_P_SA3: begin
                    cx_reg <= COORD_W'(MUL_W'(sx_reg) + sgn_q(dx_reg < 0,
                              QUO_W'(rnd_a[PROD_W-3:COORD_W])));
                    cy_reg <= COORD_W'(MUL_W'(sy_reg) + sgn_q(dy_reg < 0,
                              QUO_W'(rnd_b[PROD_W-3:COORD_W])));
                    state_reg <= ST_P_DIST;
                end
                ST_P_DIST: state_reg <= ST_P_D2;
                ST_P_D2: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_P_D3;
                end
                ST_P_D3: begin
                    // first strict minimum wins
                    if ((idx_reg == '0) || (psum[LEN2_W-1:0] < best_reg)) begin
                        best_reg <= psum[LEN2_W-1:0];
                        bx_reg   <= cx_reg;
                        by_reg   <= cy_reg;
                    end
                    state_reg <= ST_P_ADV;
                end
                ST_P_ADV: begin
                    sx_reg    <= ex_reg;
                    sy_reg    <= ey_reg;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= (idx_reg == last) ? ST_P_CEN : ST_P_LOADE;
                end
                ST_P_CEN: state_reg <= ST_P_CX;
                ST_P_CX: begin
                    if (div_rsp.done) begin
                        ux_reg    <= sgn_q(sumx_reg < 0, div_rsp.quot) - MUL_W'(bx_reg);
                        state_reg <= ST_P_CY;
                    end
                end
                ST_P_CY: begin
                    if (div_rsp.done) begin
                        uy_reg    <= sgn_q(sumy_reg < 0, div_rsp.quot) - MUL_W'(by_reg);
                        state_reg <= ST_P_U0;
                    end
                end
                ST_P_U0: begin
                    if ((ux_reg == 0) && (uy_reg == 0)) begin
                        stepx_reg <= '0;
                        stepy_reg <= '0;
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_P_U1;
                    end
                end
                ST_P_U1: begin
                    t1_reg    <= mul_p_reg;
                    state_reg <= ST_P_U2;
                end
                ST_P_U2: state_reg <= ST_P_SQ;
                ST_P_SQ: begin
                    if (sqrt_rsp.done) begin
                        len_reg   <= sqrt_rsp.root;
                        state_reg <= ST_P_S1;
                    end
                end
                ST_P_S1: state_reg <= ST_P_S2;
                ST_P_S2: state_reg <= ST_P_SX;
                ST_P_SX: begin
                    if (div_rsp.done) begin
                        stepx_reg <= sgn_q(ux_reg < 0, div_rsp.quot);
                        state_reg <= ST_P_S3;
                    end
                end
                ST_P_S3: state_reg <= ST_P_SY;
                ST_P_SY: begin
                    if (div_rsp.done) begin
                        stepy_reg <= sgn_q(uy_reg < 0, div_rsp.quot);
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    resx_reg  <= sat(bx_reg, stepx_reg);
                    resy_reg  <= sat(by_reg, stepy_reg);
                    resp_reg  <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the output register frees up
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {resy_reg, resx_reg};
                        m_user_reg  <= resp_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_sqrt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_req.start |-> !sqrt_rsp.busy)
        else $error("square root started while busy");

    a_load_no_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == CMD_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("vertex load left the idle state");

    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_P_D3) |-> (idx_reg < n_eff))
        else $error("edge index beyond vertex count");

    a_proj_needs_poly: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) |-> (n_eff >= CNT_W'(3))))
        else $error("projection with fewer than three vertices");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the polygon guard: loads polygons of varied shape and size through the
// input stream, sends query points around and across their boundaries, and
// compares every result item field by field with an exact integer predictor
// that tracks the vertex slots and the two registers.
// ----------------------------------------------------------------------------
module tb;
    import pip_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam longint C_MAX = 64'sd2147483647;
    localparam longint C_MIN = -64'sd2147483648;
    localparam real    PI = 3.14159265358979;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic              cmd;
        logic [5:0]        slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } poly_item_t;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic               moved;
    } guard_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAD_W-1:0]     cfg_data = '0;

    // predictor state
    longint      vert_x [MAX_VERTICES];
    longint      vert_y [MAX_VERTICES];
    logic [6:0]  vcount_reg = '0;
    logic [23:0] pad_reg = '0;

    poly_item_t    pending_items[$];
    guard_result_t expected_points[$];
    poly_item_t    held_item;
    int            in_gap = 0;
    int            out_gap = 0;
    int            stall_left = 0;
    bit            stall_request = 0;
    bit            steady_mode = 0;
    int            errors = 0;
    int            total_items = 0;
    longint        cycles = 0;

    project_point_inside_polygon_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp32(longint v);
        return v > C_MAX ? C_MAX : (v < C_MIN ? C_MIN : v);
    endfunction

    function automatic longint scale_alpha(longint v, longint alpha);
        logic [127:0] m;
        m = 128'(mag(v)) * 128'(alpha) + (128'd1 << 31);
        return v < 0 ? -longint'(m[95:32]) : longint'(m[95:32]);
    endfunction

    function automatic longint scale_dir(longint comp, longint pad, longint len);
        logic [127:0] num, q;
        num = ((128'(mag(comp)) * 128'(pad)) << 17) + 128'(len);
        q = num / (128'(len) << 1);
        return comp < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint root_floor(logic [127:0] rad);
        logic [63:0] r, t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= rad) r = t;
        end
        return longint'(r);
    endfunction

    function automatic longint centroid_axis(longint sum, longint n);
        longint q;
        q = (2 * mag(sum) + n) / (2 * n);
        return sum < 0 ? -q : q;
    endfunction

    task automatic nearest_on_edge(input longint px, py, sx, sy, ex, ey,
                                   output longint cx, cy);
        wide_t dx, dy, len2, dot, alpha;
        dx = ex - sx;
        dy = ey - sy;
        len2 = dx * dx + dy * dy;
        cx = sx;
        cy = sy;
        if (len2 <= 65536) return;
        dot = wide_t'(px - sx) * dx + wide_t'(py - sy) * dy;
        if (dot <= 0) return;
        if (dot >= len2) begin
            cx = ex;
            cy = ey;
            return;
        end
        alpha = (dot <<< 32) / len2;
        cx = sx + scale_alpha(longint'(dx), longint'(alpha));
        cy = sy + scale_alpha(longint'(dy), longint'(alpha));
    endtask

    function automatic bit point_inside(longint x, longint y, int n);
        bit    odd;
        int    prev;
        longint den;
        wide_t aa, bb;
        odd = 0;
        prev = n - 1;
        for (int cur = 0; cur < n; cur++) begin
            if ((vert_y[cur] > y) != (vert_y[prev] > y)) begin
                den = vert_y[prev] - vert_y[cur];
                aa = wide_t'(x - vert_x[cur]) * wide_t'(den);
                bb = wide_t'(vert_x[prev] - vert_x[cur]) * wide_t'(y - vert_y[cur]);
                if (den > 0 ? aa < bb : aa > bb) odd = !odd;
            end
            prev = cur;
        end
        return odd;
    endfunction

    task automatic apply_item(input poly_item_t it);
        guard_result_t res;
        longint x, y, bx, by, cx, cy, sumx, sumy, ux, uy, len, rx, ry;
        wide_t  d2, best_d2, ex, ey, l2;
        int     n, j;
        if (it.cmd == CMD_LOAD) begin
            vert_x[it.slot] = it.x;
            vert_y[it.slot] = it.y;
            return;
        end
        x = it.x;
        y = it.y;
        rx = x;
        ry = y;
        res.moved = 1'b0;
        n = vcount_reg > MAX_VERTICES ? MAX_VERTICES : int'(vcount_reg);
        if (n >= 3 && !point_inside(x, y, n)) begin
            best_d2 = 0;
            bx = vert_x[0];
            by = vert_y[0];
            sumx = 0;
            sumy = 0;
            for (int i = 0; i < n; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                nearest_on_edge(x, y, vert_x[i], vert_y[i], vert_x[j], vert_y[j], cx, cy);
                ex = x - cx;
                ey = y - cy;
                d2 = ex * ex + ey * ey;
                if (i == 0 || d2 < best_d2) begin
                    best_d2 = d2;
                    bx = cx;
                    by = cy;
                end
                sumx += vert_x[i];
                sumy += vert_y[i];
            end
            ux = centroid_axis(sumx, n) - bx;
            uy = centroid_axis(sumy, n) - by;
            rx = bx;
            ry = by;
            if (ux != 0 || uy != 0) begin
                l2 = wide_t'(ux) * wide_t'(ux) + wide_t'(uy) * wide_t'(uy);
                len = root_floor(128'(l2) << 32);
                rx += scale_dir(ux, longint'(pad_reg), len);
                ry += scale_dir(uy, longint'(pad_reg), len);
            end
            rx = clamp32(rx);
            ry = clamp32(ry);
            res.moved = 1'b1;
        end
        res.rx = rx[31:0];
        res.ry = ry[31:0];
        expected_points.push_back(res);
    endtask

    // ---------------- driver and monitor ----------------
    function automatic int pick_gap();
        int r;
        if (steady_mode) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_item(held_item);
            if (!s_tvalid || s_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    held_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= held_item.cmd;
                    s_tdata <= {2'b00, held_item.y, held_item.x, held_item.slot};
                    in_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with random idling and one long hold-off on request
    always @(posedge aclk) begin
        if (stall_request) begin
            stall_request = 0;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    task automatic report_mismatch(string field, longint want, longint got);
        $display("mismatch %s: expected %0d got %0d at cycle %0d", field, want, got, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        guard_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected result item", 0, 1);
            end else begin
                want = expected_points.pop_front();
                if ($signed(m_tdata[31:0]) !== want.rx)
                    report_mismatch("result_x", want.rx, $signed(m_tdata[31:0]));
                if ($signed(m_tdata[63:32]) !== want.ry)
                    report_mismatch("result_y", want.ry, $signed(m_tdata[63:32]));
                if (m_tuser !== want.moved)
                    report_mismatch("was_projected", want.moved, m_tuser);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_item(logic cmd, int slot, longint x, longint y);
        poly_item_t it;
        it.cmd = cmd;
        it.slot = slot[5:0];
        it.x = clamp32(x);
        it.y = clamp32(y);
        pending_items.push_back(it);
        total_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAD_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_VERTEX_COUNT) vcount_reg = val[6:0];
        else if (idx == REG_PADDING) pad_reg = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_points.size() > 0);
        repeat (30) @(negedge aclk);
    endtask

    function automatic longint rand_coord();
        return longint'(int'($urandom()));
    endfunction

    function automatic longint spread(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    // load slots 0..n-1 with a polygon: convex, star shaped, or with a repeated vertex
    task automatic load_polygon(int n, int shape, longint cx, longint cy, longint r);
        real ang, rr;
        int  dup;
        dup = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
            ang = 2.0 * PI * (k + $urandom_range(0, 80) / 100.0) / n;
            rr = (shape == 1) ? r * ($urandom_range(25, 100) / 100.0) : r;
            if (shape == 2 && k == dup && k > 0)
                push_item(CMD_LOAD, k, pending_items[$].x, pending_items[$].y);
            else
                push_item(CMD_LOAD, k, cx + longint'($rtoi(rr * $cos(ang))),
                          cy + longint'($rtoi(rr * $sin(ang))));
        end
    endtask

    task automatic run_phase(int vcount, int pad, int n_queries);
        int     n, r, shape;
        longint cx, cy, rad;
        write_reg(REG_VERTEX_COUNT, PAD_W'(vcount));
        write_reg(REG_PADDING, PAD_W'(pad));
        n = vcount > MAX_VERTICES ? MAX_VERTICES : vcount;
        r = $urandom_range(99);
        if (r < 8) begin
            // near the corners of the range, to drive saturation
            cx = $urandom_range(1) ? C_MAX - 4000 : C_MIN + 4000;
            cy = $urandom_range(1) ? C_MAX - 4000 : C_MIN + 4000;
        end else begin
            cx = spread(1 << 22);
            cy = spread(1 << 22);
        end
        rad = (r % 10 == 3) ? $urandom_range(40, 200) : $urandom_range(256, 1 << 20);
        shape = $urandom_range(2);
        if (n >= 1) load_polygon(n, shape, cx, cy, rad);
        for (int q = 0; q < n_queries; q++) begin
            r = $urandom_range(99);
            if (r < 60)
                push_item(CMD_QUERY, $urandom_range(63), cx + spread(2 * rad), cy + spread(2 * rad));
            else if (r < 70 && n > 0)
                push_item(CMD_QUERY, $urandom_range(63), pending_items[0].x, pending_items[0].y);
            else if (r < 82)
                push_item(CMD_QUERY, $urandom_range(63), rand_coord(), rand_coord());
            else if (r < 92 && n < MAX_VERTICES)
                // spare slot, never used under the current count
                push_item(CMD_LOAD, $urandom_range(n, 63), rand_coord(), rand_coord());
            else if (n > 0)
                // move one in-use vertex a little
                push_item(CMD_LOAD, $urandom_range(0, n - 1),
                          cx + spread(rad), cy + spread(rad));
        end
        wait_drained();
    endtask

    initial begin
        int phase;
        int vc, pd;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // empty polygon: everything passes through unchanged
        write_reg(2'd2, '1);
        write_reg(2'd3, '0);
        push_item(CMD_QUERY, 0, C_MIN, C_MIN);
        push_item(CMD_QUERY, 63, C_MAX, C_MAX);
        push_item(CMD_QUERY, 21, 0, -1);
        push_item(CMD_LOAD, 63, C_MAX, C_MIN);
        push_item(CMD_LOAD, 0, C_MIN, C_MAX);
        push_item(CMD_LOAD, 1, 0, 0);
        wait_drained();
        write_reg(REG_VERTEX_COUNT, 24'd2);
        push_item(CMD_QUERY, 42, 12345, -777);
        wait_drained();

        // triangle: inside, outside past a vertex, outside an edge, on a vertex
        write_reg(REG_VERTEX_COUNT, 24'd3);
        write_reg(REG_PADDING, 24'd256);
        push_item(CMD_LOAD, 0, 0, 0);
        push_item(CMD_LOAD, 1, 25600, 0);
        push_item(CMD_LOAD, 2, 0, 25600);
        push_item(CMD_QUERY, 0, 2560, 2560);
        push_item(CMD_QUERY, 0, -5000, -5000);
        push_item(CMD_QUERY, 0, 12800, -3000);
        push_item(CMD_QUERY, 0, 25600, 0);
        push_item(CMD_QUERY, 0, 20000, 20000);
        push_item(CMD_QUERY, 0, C_MAX, C_MIN);
        wait_drained();
        write_reg(REG_PADDING, 24'hFFFFFF);
        push_item(CMD_QUERY, 0, -5000, 12800);
        push_item(CMD_QUERY, 0, C_MIN, C_MIN);
        wait_drained();

        phase = 0;
        while (total_items < 1370) begin
            vc = $urandom_range(99);
            if (phase == 4) vc = 64;
            else if (phase == 9) vc = 127;
            else if (vc < 75) vc = $urandom_range(3, 8);
            else if (vc < 93) vc = $urandom_range(9, 20);
            else vc = $urandom_range(0, 2);
            pd = $urandom_range(3);
            pd = pd == 0 ? 0 : (pd == 1 ? 24'hFFFFFF : (pd == 2 ? $urandom_range(0, 4096)
                                                                : $urandom_range(0, 24'hFFFFFF)));
            steady_mode = ($urandom_range(4) == 0);
            if (phase == 2) stall_request = 1;
            run_phase(vc, pd, (vc > 20) ? 16 : 55);
            phase++;
        end
        steady_mode = 0;
        wait_drained();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
